>>> src/sso_pkg.sv
// Shared types, widths and opcodes for the sphere set overlap block.
`timescale 1ns / 1ps

package sso_pkg;

  // Default number of sphere slots per set
  localparam int SPHERE_SLOTS_DEF = 32;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 5;
  localparam int COORD_W = 24;
  localparam int RAD_W   = 16;
  localparam int COUNT_W = 6;
  localparam int MASK_W  = 32;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;   // coordinate difference, also its magnitude
  localparam int SQ_W   = 2 * DIFF_W;    // squared axis distance
  localparam int SUM_W  = SQ_W + 2;      // sum of three squares
  localparam int RS_W   = RAD_W;         // sum of two positive radii
  localparam int RS2_W  = 2 * RS_W;      // squared radius sum

  typedef enum logic [OP_W-1:0] {
    OP_STORE_A = 2'd0,
    OP_STORE_B = 2'd1,
    OP_TEST    = 2'd2
  } op_e;

  // One stored sphere
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [RAD_W-1:0]   r;
  } sphere_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_a;       // write set A entry
    logic wr_b;       // write set B entry
    logic clear;      // clear working masks
    logic issue;      // launch one pair into the compare pipeline
    logic take_hit;   // record the hit at the pipeline end
    logic load_out;   // copy working masks into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;       // some pair still in flight
    logic hit;        // overlapping pair at the pipeline end
  } status_t;

endpackage

>>> src/sso_if.sv
// Handshake channel interfaces for the sphere set overlap block.
`timescale 1ns / 1ps

interface sso_in_if;
  import sso_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic signed [RAD_W-1:0]   radius;
  logic [COUNT_W-1:0]        count_a;
  logic [COUNT_W-1:0]        count_b;

  modport source (
    output valid, op, slot, center_x, center_y, center_z, radius, count_a, count_b,
    input  ready
  );

  modport sink (
    input  valid, op, slot, center_x, center_y, center_z, radius, count_a, count_b,
    output ready
  );
endinterface

interface sso_out_if;
  import sso_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] mask_a;
  logic [MASK_W-1:0] mask_b;

  modport source (
    output valid, mask_a, mask_b,
    input  ready
  );

  modport sink (
    input  valid, mask_a, mask_b,
    output ready
  );
endinterface

>>> src/sso_dp.sv
// Datapath: sphere memories, pair compare pipeline, mask and output registers.
`timescale 1ns / 1ps

module sso_dp import sso_pkg::*; #(
  parameter int SPHERE_SLOTS = SPHERE_SLOTS_DEF,
  parameter int IDX_W        = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [IDX_W-1:0]  wr_slot_i,
  input  sphere_t           wr_data_i,
  input  logic [IDX_W-1:0]  rd_a_idx_i,
  input  logic [IDX_W-1:0]  rd_b_idx_i,
  output status_t           status_o,
  output logic [IDX_W-1:0]  hit_a_idx_o,
  output logic [MASK_W-1:0] mask_a_o,
  output logic [MASK_W-1:0] mask_b_o
);

  // Sphere stores, one write and one read port each
  sphere_t mem_a_q [SPHERE_SLOTS];
  sphere_t mem_b_q [SPHERE_SLOTS];

  // Stage 1: read data
  logic             v1_q;
  logic [IDX_W-1:0] i1_q, j1_q;
  sphere_t          a1_q, b1_q;

  // Stage 2: magnitudes of the differences and radius sum
  logic              v2_q, pos2_q;
  logic [IDX_W-1:0]  i2_q, j2_q;
  logic [DIFF_W-1:0] ax2_q, ay2_q, az2_q;
  logic [RS_W-1:0]   rs2_q;

  // Stage 3: squares
  logic             v3_q, pos3_q;
  logic [IDX_W-1:0] i3_q, j3_q;
  logic [SQ_W-1:0]  sqx3_q, sqy3_q, sqz3_q;
  logic [RS2_W-1:0] rsq3_q;

  // Stage 4: distance sum
  logic             v4_q, pos4_q;
  logic [IDX_W-1:0] i4_q, j4_q;
  logic [SUM_W-1:0] sum4_q;
  logic [RS2_W-1:0] rsq4_q;

  // Stage 5: compare result
  logic             v5_q, hit5_q;
  logic [IDX_W-1:0] i5_q, j5_q;

  // Working and output masks
  logic [MASK_W-1:0] mask_a_q, mask_b_q;
  logic [MASK_W-1:0] out_a_q, out_b_q;

  // Stage 2 combinational terms
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0]        ax, ay, az;
  logic [RS_W:0]            rsum;
  logic                     pos;

  // Write the stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a_q[wr_slot_i] <= wr_data_i;
    end
    if (cmd_i.wr_b) begin
      mem_b_q[wr_slot_i] <= wr_data_i;
    end
  end

  // Read the stores
  always_ff @(posedge clk_i) begin
    a1_q <= mem_a_q[rd_a_idx_i];
    b1_q <= mem_b_q[rd_b_idx_i];
  end

  // Differences, magnitudes and radius sum
  always_comb begin
    dx   = DIFF_W'(a1_q.x) - DIFF_W'(b1_q.x);
    dy   = DIFF_W'(a1_q.y) - DIFF_W'(b1_q.y);
    dz   = DIFF_W'(a1_q.z) - DIFF_W'(b1_q.z);
    ax   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az   = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    rsum = {1'b0, a1_q.r} + {1'b0, b1_q.r};
    pos  = (a1_q.r > 16'sd0) && (b1_q.r > 16'sd0);
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance the pipeline payload
  always_ff @(posedge clk_i) begin
    i1_q   <= rd_a_idx_i;
    j1_q   <= rd_b_idx_i;

    i2_q   <= i1_q;
    j2_q   <= j1_q;
    ax2_q  <= ax;
    ay2_q  <= ay;
    az2_q  <= az;
    rs2_q  <= rsum[RS_W-1:0];
    pos2_q <= pos;

    i3_q   <= i2_q;
    j3_q   <= j2_q;
    sqx3_q <= ax2_q * ax2_q;
    sqy3_q <= ay2_q * ay2_q;
    sqz3_q <= az2_q * az2_q;
    rsq3_q <= rs2_q * rs2_q;
    pos3_q <= pos2_q;

    i4_q   <= i3_q;
    j4_q   <= j3_q;
    sum4_q <= SUM_W'(sqx3_q) + SUM_W'(sqy3_q) + SUM_W'(sqz3_q);
    rsq4_q <= rsq3_q;
    pos4_q <= pos3_q;

    i5_q   <= i4_q;
    j5_q   <= j4_q;
    hit5_q <= pos4_q && (sum4_q < SUM_W'(rsq4_q));
  end

  // Accumulate the masks, hold the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mask_a_q <= '0;
      mask_b_q <= '0;
    end else if (cmd_i.take_hit) begin
      mask_a_q <= mask_a_q | (MASK_W'(1) << i5_q);
      mask_b_q <= mask_b_q | (MASK_W'(1) << j5_q);
    end
    if (cmd_i.load_out) begin
      out_a_q <= mask_a_q;
      out_b_q <= mask_b_q;
    end
  end

  assign status_o.busy = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign status_o.hit  = v5_q & hit5_q;
  assign hit_a_idx_o   = i5_q;
  assign mask_a_o      = out_a_q;
  assign mask_b_o      = out_b_q;

endmodule

>>> src/sso_ctrl.sv
// Controller: handshakes, pair scan sequencing and first-hit bookkeeping.
`timescale 1ns / 1ps

module sso_ctrl import sso_pkg::*; #(
  parameter int SPHERE_SLOTS = SPHERE_SLOTS_DEF,
  parameter int IDX_W        = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [OP_W-1:0]    in_op_i,
  input  logic [SLOT_W-1:0]  in_slot_i,
  input  logic [COUNT_W-1:0] in_count_a_i,
  input  logic [COUNT_W-1:0] in_count_b_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmd_t               cmd_o,
  input  status_t            status_i,
  input  logic [IDX_W-1:0]   hit_a_idx_i,
  output logic [IDX_W-1:0]   rd_a_idx_o,
  output logic [IDX_W-1:0]   rd_b_idx_o
);

  localparam int CNT_W = $clog2(SPHERE_SLOTS + 1);
  localparam int PW    = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ii_q, ii_d, jj_q, jj_d;
  logic [CNT_W-1:0] na_q, na_d, nb_q, nb_d;
  logic [IDX_W-1:0] hit_row_q, hit_row_d;
  logic             hit_row_vld_q, hit_row_vld_d;
  logic             out_valid_q, out_valid_d;

  logic             in_accept;
  logic             slot_ok;
  logic [CNT_W-1:0] na_sat, nb_sat;
  logic             take_hit;
  logic             i_last, j_last, hit_last;

  // Decode the transfer and saturate the counts
  always_comb begin
    in_accept = in_valid_i && (state_q == ST_IDLE);
    slot_ok   = int'(in_slot_i) < SPHERE_SLOTS;
    na_sat    = (int'(in_count_a_i) > SPHERE_SLOTS) ? CNT_W'(SPHERE_SLOTS)
                                                    : CNT_W'(in_count_a_i);
    nb_sat    = (int'(in_count_b_i) > SPHERE_SLOTS) ? CNT_W'(SPHERE_SLOTS)
                                                    : CNT_W'(in_count_b_i);
    // Drop hits of a row that already has its first hit
    take_hit  = status_i.hit && !(hit_row_vld_q && (hit_a_idx_i == hit_row_q));
    i_last    = (PW'(ii_q) + PW'(1)) == PW'(na_q);
    j_last    = (PW'(jj_q) + PW'(1)) == PW'(nb_q);
    hit_last  = (PW'(hit_a_idx_i) + PW'(1)) == PW'(na_q);
  end

  // Sequence the scan
  always_comb begin
    state_d       = state_q;
    ii_d          = ii_q;
    jj_d          = jj_q;
    na_d          = na_q;
    nb_d          = nb_q;
    hit_row_d     = hit_row_q;
    hit_row_vld_d = hit_row_vld_q;
    cmd_o         = '0;

    cmd_o.wr_a     = in_accept && (in_op_i == OP_STORE_A) && slot_ok;
    cmd_o.wr_b     = in_accept && (in_op_i == OP_STORE_B) && slot_ok;
    cmd_o.take_hit = take_hit;

    if (take_hit) begin
      hit_row_d     = hit_a_idx_i;
      hit_row_vld_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_op_i == OP_TEST)) begin
          cmd_o.clear   = 1'b1;
          na_d          = na_sat;
          nb_d          = nb_sat;
          ii_d          = '0;
          jj_d          = '0;
          hit_row_vld_d = 1'b0;
          state_d       = ((na_sat == '0) || (nb_sat == '0)) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (take_hit && (hit_a_idx_i == ii_q)) begin
          // Skip the rest of the row that just hit
          ii_d = hit_a_idx_i + IDX_W'(1);
          jj_d = '0;
          if (hit_last) begin
            state_d = ST_DRAIN;
          end
        end else if (j_last) begin
          ii_d = ii_q + IDX_W'(1);
          jj_d = '0;
          if (i_last) begin
            state_d = ST_DRAIN;
          end
        end else begin
          jj_d = jj_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ii_q          <= '0;
      jj_q          <= '0;
      na_q          <= '0;
      nb_q          <= '0;
      hit_row_q     <= '0;
      hit_row_vld_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ii_q          <= ii_d;
      jj_q          <= jj_d;
      na_q          <= na_d;
      nb_q          <= nb_d;
      hit_row_q     <= hit_row_d;
      hit_row_vld_q <= hit_row_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rd_a_idx_o  = ii_q;
  assign rd_b_idx_o  = jj_q;

`ifndef NO_ASSERTIONS
  // A test transfer always leaves idle
  a_test_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_op_i == OP_TEST)) |=> (state_q != ST_IDLE))
    else $error("test transfer did not start a scan");

  // The output register is loaded only when free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  // Nothing is in flight while idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !status_i.busy)
    else $error("pair in flight while idle");

  // Hits are recorded only during a scan
  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_hit |-> ((state_q == ST_RUN) || (state_q == ST_DRAIN)))
    else $error("hit recorded outside a scan");
`endif

endmodule

>>> src/sphere_set_overlap_masks_core.sv
// Top level of the sphere set overlap block: controller plus datapath.
//
// Usage: one input channel (req_i) carries store and test items, one output
// channel (rsp_o) carries the two overlap masks; valid/ready handshakes.
// A store item (set A or set B) writes one sphere and gives no result; a
// slot at or beyond the set size is dropped, as is op 3. A test item scans
// the A spheres in order against the B spheres in order, one pair per cycle
// through a five-stage compare pipeline (memory read, differences, squares,
// sum, compare). A row ends at its first hit. New items are taken only while
// no test is running; a stored result waits in the output register while the
// next stores are taken, and a finished test stalls until that register is
// free. Reset clears the controller and the output valid; sphere memories
// are not cleared and must be written before a test reads them.
`timescale 1ns / 1ps

module sphere_set_overlap_masks_core import sso_pkg::*; #(
  parameter int SPHERE_SLOTS = SPHERE_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sso_in_if.sink    req_i,
  sso_out_if.source rsp_o
);

  localparam int IDX_W = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_a_idx, rd_b_idx, hit_a_idx;
  sphere_t          wr_data;

  // Pack the store payload
  always_comb begin
    wr_data.x = req_i.center_x;
    wr_data.y = req_i.center_y;
    wr_data.z = req_i.center_z;
    wr_data.r = req_i.radius;
  end

  sso_ctrl #(
    .SPHERE_SLOTS (SPHERE_SLOTS),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_op_i      (req_i.op),
    .in_slot_i    (req_i.slot),
    .in_count_a_i (req_i.count_a),
    .in_count_b_i (req_i.count_b),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .status_i     (status),
    .hit_a_idx_i  (hit_a_idx),
    .rd_a_idx_o   (rd_a_idx),
    .rd_b_idx_o   (rd_b_idx)
  );

  sso_dp #(
    .SPHERE_SLOTS (SPHERE_SLOTS),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .wr_slot_i   (req_i.slot[IDX_W-1:0]),
    .wr_data_i   (wr_data),
    .rd_a_idx_i  (rd_a_idx),
    .rd_b_idx_i  (rd_b_idx),
    .status_o    (status),
    .hit_a_idx_o (hit_a_idx),
    .mask_a_o    (rsp_o.mask_a),
    .mask_b_o    (rsp_o.mask_b)
  );

endmodule
